[src/e2r_pkg.sv]
// ----------------------------------------------------------------------------
// e2r_pkg: shared types and constants for the Euler-to-rotation-matrix block
// Fixed-point formats, beat structs and the arctangent table generator.
// ----------------------------------------------------------------------------
package e2r_pkg;

  localparam int ANGLE_FRAC_BITS = 13;
  localparam int OUT_FRAC_BITS   = 14;
  localparam int WORK_FRAC       = 30;
  localparam int CORDIC_STEPS    = 30;
  localparam int WORK_W          = 34;
  localparam int MUL_W           = 32;
  localparam int FIELD_W         = 16;
  localparam int STEP_W          = $clog2(CORDIC_STEPS);

  typedef logic signed [WORK_W-1:0]  work_t;
  typedef logic signed [FIELD_W-1:0] field_t;

  localparam work_t PI_Q30      = WORK_W'(64'sd3373259426);
  localparam work_t HALF_PI_Q30 = WORK_W'(64'sd1686629713);
  localparam work_t GAIN_Q30    = WORK_W'(64'sd652032874);
  localparam longint unsigned PI_Q62 = 64'hC90FDAA22168C234;

  localparam int OUT_ONE = 1 << OUT_FRAC_BITS;
  localparam int OUT_MAX = (OUT_ONE < 32767) ? OUT_ONE : 32767;
  localparam int OUT_MIN = (-OUT_ONE > -32768) ? -OUT_ONE : -32768;

  typedef struct packed {
    field_t angle_x;
    field_t angle_y;
    field_t angle_z;
  } in_t;

  typedef struct packed {
    field_t r00;
    field_t r01;
    field_t r02;
    field_t r10;
    field_t r11;
    field_t r12;
    field_t r20;
    field_t r21;
    field_t r22;
  } out_t;

  // One CORDIC lane: vector, residual angle and the half-turn fold flag
  typedef struct packed {
    work_t x;
    work_t y;
    work_t z;
    logic  flip;
  } lane_t;

  typedef struct packed {
    lane_t ax;
    lane_t ay;
    lane_t az;
  } cordic_t;

  // atan(2^-n) in Q.30, from the alternating series in Q.62 (pi/4 from PI_Q62 for n = 0)
  function automatic longint unsigned atan_q30(input int n);
    longint unsigned acc;
    longint unsigned term;
    int              e;
    acc = 64'd0;
    if (n == 0) begin
      return ((PI_Q62 >> 2) + (64'd1 << 31)) >> 32;
    end
    for (int t = 0; t < 32; t++) begin
      e = n * (2 * t + 1);
      if (e <= 62) begin
        term = (64'd1 << (62 - e)) / 64'(unsigned'(2 * t + 1));
        if (t[0]) begin
          acc = acc - term;
        end else begin
          acc = acc + term;
        end
      end
    end
    return (acc + (64'd1 << 31)) >> 32;
  endfunction

endpackage

[src/e2r_cordic_cell.sv]
// ----------------------------------------------------------------------------
// e2r_cordic_cell: one rotation-mode CORDIC micro-rotation for three lanes
// Registers its result and hands it to the next cell when the chain advances.
// ----------------------------------------------------------------------------
module e2r_cordic_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     advance,
  input  logic [e2r_pkg::STEP_W-1:0] step_shift,
  input  e2r_pkg::work_t           atan_val,
  input  logic                     in_vld,
  input  e2r_pkg::cordic_t         in_data,
  output logic                     out_vld,
  output e2r_pkg::cordic_t         out_data
);
  import e2r_pkg::*;

  logic    vld_r;
  cordic_t data_r;
  cordic_t data_nxt;

  function automatic lane_t rotate(input lane_t l, input logic [STEP_W-1:0] sh,
                                   input work_t a);
    lane_t r;
    work_t dx;
    work_t dy;
    dx = l.y >>> sh;
    dy = l.x >>> sh;
    r  = l;
    if (!l.z[WORK_W-1]) begin
      r.x = l.x - dx;
      r.y = l.y + dy;
      r.z = l.z - a;
    end else begin
      r.x = l.x + dx;
      r.y = l.y - dy;
      r.z = l.z + a;
    end
    return r;
  endfunction

  always_comb begin
    data_nxt.ax = rotate(in_data.ax, step_shift, atan_val);
    data_nxt.ay = rotate(in_data.ay, step_shift, atan_val);
    data_nxt.az = rotate(in_data.az, step_shift, atan_val);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (advance) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      data_r <= data_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_data = data_r;

endmodule

[src/euler_to_rotation_matrix.sv]
// Euler Z-Y-X angles to rotation matrix. Each beat carries three signed Q2.13
// angles (radians, clamped to +-pi); the result beat carries the nine entries
// of R = Rz*Ry*Rx as signed Q1.14, rounded half up and saturated to +-1.0.
// The datapath is a fully pipelined chain: one decode/fold stage, thirty
// CORDIC cells (one micro-rotation each, all three angles side by side), two
// multiplier stages and the output register, and a new beat is taken every
// cycle while the chain advances. The whole chain advances together; it
// holds only while a finished result sits in the output register and the
// sink stalls. There is no state between beats and no configuration.
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix: pipelined Euler angle to rotation matrix unit
// Decode, CORDIC cell chain, products and rounding to Q1.14.
// ----------------------------------------------------------------------------
module euler_to_rotation_matrix (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  e2r_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output e2r_pkg::out_t out_data
);
  import e2r_pkg::*;

  localparam int ANGLE_SHIFT = WORK_FRAC - ANGLE_FRAC_BITS;
  localparam int RND_SHIFT   = WORK_FRAC - OUT_FRAC_BITS;

  // Advance the whole chain unless a result is held by the sink
  logic advance;
  logic out_vld_r;
  out_t out_r;
  out_t out_nxt;

  assign advance  = !out_vld_r || !out_stall;
  assign in_stall = !advance;

  // Saturate to +-pi, then fold into +-pi/2 by a half turn
  function automatic lane_t decode(input field_t ang);
    lane_t l;
    work_t a;
    a = WORK_W'(ang) <<< ANGLE_SHIFT;
    if (a > PI_Q30) begin
      a = PI_Q30;
    end else if (a < -PI_Q30) begin
      a = -PI_Q30;
    end
    l.x    = GAIN_Q30;
    l.y    = '0;
    l.flip = 1'b0;
    if (a > HALF_PI_Q30) begin
      l.z    = a - PI_Q30;
      l.flip = 1'b1;
    end else if (a < -HALF_PI_Q30) begin
      l.z    = a + PI_Q30;
      l.flip = 1'b1;
    end else begin
      l.z = a;
    end
    return l;
  endfunction

  // Q.30 product, rounded half up
  function automatic work_t qmul(input work_t a, input work_t b);
    logic signed [MUL_W-1:0]   a_s;
    logic signed [MUL_W-1:0]   b_s;
    logic signed [2*MUL_W-1:0] p;
    a_s = a[MUL_W-1:0];
    b_s = b[MUL_W-1:0];
    p   = a_s * b_s;
    p   = p + (64'sd1 <<< (WORK_FRAC - 1));
    return WORK_W'(p >>> WORK_FRAC);
  endfunction

  // Round Q.30 to the output format and saturate
  function automatic field_t encode(input work_t v);
    work_t r;
    r = (v + (WORK_W'(1) <<< (RND_SHIFT - 1))) >>> RND_SHIFT;
    if (r > WORK_W'(OUT_MAX)) begin
      r = WORK_W'(OUT_MAX);
    end else if (r < WORK_W'(OUT_MIN)) begin
      r = WORK_W'(OUT_MIN);
    end
    return r[FIELD_W-1:0];
  endfunction

  // Chain of CORDIC cells; entry 0 is the decode stage
  logic    chain_vld  [CORDIC_STEPS+1];
  cordic_t chain_data [CORDIC_STEPS+1];
  logic    pre_vld_r;
  cordic_t pre_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_vld_r <= 1'b0;
    end else if (advance) begin
      pre_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pre_r.ax <= decode(in_data.angle_x);
      pre_r.ay <= decode(in_data.angle_y);
      pre_r.az <= decode(in_data.angle_z);
    end
  end

  assign chain_vld[0]  = pre_vld_r;
  assign chain_data[0] = pre_r;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    localparam work_t ATAN_I = WORK_W'(atan_q30(i));
    e2r_cordic_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .advance    (advance),
      .step_shift (STEP_W'(i)),
      .atan_val   (ATAN_I),
      .in_vld     (chain_vld[i]),
      .in_data    (chain_data[i]),
      .out_vld    (chain_vld[i+1]),
      .out_data   (chain_data[i+1])
    );
  end

  // Undo the fold: a half turn negates cosine and sine
  work_t cx, sx, cy, sy, cz, sz;
  cordic_t fin;
  assign fin = chain_data[CORDIC_STEPS];
  assign cx  = fin.ax.flip ? -fin.ax.x : fin.ax.x;
  assign sx  = fin.ax.flip ? -fin.ax.y : fin.ax.y;
  assign cy  = fin.ay.flip ? -fin.ay.x : fin.ay.x;
  assign sy  = fin.ay.flip ? -fin.ay.y : fin.ay.y;
  assign cz  = fin.az.flip ? -fin.az.x : fin.az.x;
  assign sz  = fin.az.flip ? -fin.az.y : fin.az.y;

  // First product stage
  logic  m1_vld_r;
  work_t czcy_r, szcy_r, cysx_r, cycx_r, czsy_r, szsy_r;
  work_t szcx_r, szsx_r, czcx_r, czsx_r, sx_r, cx_r, nsy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r <= 1'b0;
    end else if (advance) begin
      m1_vld_r <= chain_vld[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      czcy_r <= qmul(cz, cy);
      szcy_r <= qmul(sz, cy);
      cysx_r <= qmul(cy, sx);
      cycx_r <= qmul(cy, cx);
      czsy_r <= qmul(cz, sy);
      szsy_r <= qmul(sz, sy);
      szcx_r <= qmul(sz, cx);
      szsx_r <= qmul(sz, sx);
      czcx_r <= qmul(cz, cx);
      czsx_r <= qmul(cz, sx);
      sx_r   <= sx;
      cx_r   <= cx;
      nsy_r  <= -sy;
    end
  end

  // Second product stage: triple products and the sums
  logic  m2_vld_r;
  work_t e00_r, e01_r, e02_r, e10_r, e11_r, e12_r, e20_r, e21_r, e22_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_vld_r <= 1'b0;
    end else if (advance) begin
      m2_vld_r <= m1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      e00_r <= czcy_r;
      e01_r <= qmul(czsy_r, sx_r) - szcx_r;
      e02_r <= qmul(czsy_r, cx_r) + szsx_r;
      e10_r <= szcy_r;
      e11_r <= qmul(szsy_r, sx_r) + czcx_r;
      e12_r <= qmul(szsy_r, cx_r) - czsx_r;
      e20_r <= nsy_r;
      e21_r <= cysx_r;
      e22_r <= cycx_r;
    end
  end

  // Output register: round and saturate
  always_comb begin
    out_nxt.r00 = encode(e00_r);
    out_nxt.r01 = encode(e01_r);
    out_nxt.r02 = encode(e02_r);
    out_nxt.r10 = encode(e10_r);
    out_nxt.r11 = encode(e11_r);
    out_nxt.r12 = encode(e12_r);
    out_nxt.r20 = encode(e20_r);
    out_nxt.r21 = encode(e21_r);
    out_nxt.r22 = encode(e22_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= m2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid straight after reset");
  a_hold_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(pre_vld_r) && $stable(m2_vld_r))
    else $error("chain moved while result held");
  a_entry_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.r00 <= field_t'(OUT_MAX)) && (out_data.r00 >= field_t'(OUT_MIN))
               && (out_data.r11 <= field_t'(OUT_MAX)) && (out_data.r11 >= field_t'(OUT_MIN))
               && (out_data.r22 <= field_t'(OUT_MAX)) && (out_data.r22 >= field_t'(OUT_MIN)))
    else $error("diagonal entry beyond unit range");
`endif

endmodule

[sim/e2r_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// e2r_checker: matrix predictor and scoreboard for euler_to_rotation_matrix
// Watches both channels, predicts nine Q1.14 entries per angle beat with a
// bit-exact CORDIC model, and compares result beats in order.
// ----------------------------------------------------------------------------
module e2r_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_stall,
  input  e2r_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_stall,
  input  e2r_pkg::out_t out_data,
  output int            fail_count,
  output int            pending
);
  import e2r_pkg::*;

  localparam longint PI_W   = 64'sd3373259426;
  localparam longint HALF_W = 64'sd1686629713;
  localparam longint GAIN_W = 64'sd652032874;

  longint atan_tab [CORDIC_STEPS];
  out_t   matrix_q [$];
  int     mismatches;

  initial begin
    for (int n = 0; n < CORDIC_STEPS; n++) begin
      atan_tab[n] = longint'(atan_q30(n));
    end
  end

  function automatic longint angle_q30(field_t raw);
    longint a;
    a = longint'(raw) * (64'sd1 <<< (WORK_FRAC - ANGLE_FRAC_BITS));
    if (a > PI_W) a = PI_W;
    if (a < -PI_W) a = -PI_W;
    return a;
  endfunction

  task automatic rotate(input longint ang, output longint co, output longint si);
    longint xv, yv, zv, dx, dy;
    bit     flip;
    xv = GAIN_W; yv = 0; zv = ang; flip = 0;
    if (zv > HALF_W) begin
      zv -= PI_W; flip = 1;
    end else if (zv < -HALF_W) begin
      zv += PI_W; flip = 1;
    end
    for (int n = 0; n < CORDIC_STEPS; n++) begin
      dx = yv >>> n;
      dy = xv >>> n;
      if (zv >= 0) begin
        xv -= dx; yv += dy; zv -= atan_tab[n];
      end else begin
        xv += dx; yv -= dy; zv += atan_tab[n];
      end
    end
    co = flip ? -xv : xv;
    si = flip ? -yv : yv;
  endtask

  function automatic longint qmul(longint a, longint b);
    return (a * b + (64'sd1 <<< (WORK_FRAC - 1))) >>> WORK_FRAC;
  endfunction

  function automatic field_t to_entry(longint v);
    longint one;
    one = 64'sd1 <<< OUT_FRAC_BITS;
    if (WORK_FRAC > OUT_FRAC_BITS)
      v = (v + (64'sd1 <<< (WORK_FRAC - OUT_FRAC_BITS - 1))) >>> (WORK_FRAC - OUT_FRAC_BITS);
    if (v > one) v = one;
    if (v < -one) v = -one;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return field_t'(v);
  endfunction

  task automatic predict_matrix(input in_t a, output out_t m);
    longint cx, sx, cy, sy, cz, sz, czsy, szsy;
    rotate(angle_q30(a.angle_x), cx, sx);
    rotate(angle_q30(a.angle_y), cy, sy);
    rotate(angle_q30(a.angle_z), cz, sz);
    czsy  = qmul(cz, sy);
    szsy  = qmul(sz, sy);
    m.r00 = to_entry(qmul(cz, cy));
    m.r01 = to_entry(qmul(czsy, sx) - qmul(sz, cx));
    m.r02 = to_entry(qmul(czsy, cx) + qmul(sz, sx));
    m.r10 = to_entry(qmul(sz, cy));
    m.r11 = to_entry(qmul(szsy, sx) + qmul(cz, cx));
    m.r12 = to_entry(qmul(szsy, cx) - qmul(cz, sx));
    m.r20 = to_entry(-sy);
    m.r21 = to_entry(qmul(cy, sx));
    m.r22 = to_entry(qmul(cy, cx));
  endtask

  assign pending = matrix_q.size();

  always @(posedge clk) begin
    out_t m, want;
    if (!rst_n) begin
      fail_count <= 0;
      mismatches = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_matrix(in_data, m);
        matrix_q.push_back(m);
      end
      if (out_valid && !out_stall) begin
        if (matrix_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %h", out_data);
        end else begin
          want = matrix_q.pop_front();
          if (want !== out_data) begin
            mismatches++;
            if (mismatches <= 10)
              $display("matrix mismatch: expected %h got %h", want, out_data);
          end
        end
      end
      fail_count <= mismatches;
    end
  end
endmodule

[sim/tb_euler_to_rotation_matrix.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_euler_to_rotation_matrix: stimulus and verdict for the matrix unit
// Directed corner angles, then random angle beats under random idling,
// a long sink hold-off and a drain pause; the checker scores each result.
// ----------------------------------------------------------------------------
module tb_euler_to_rotation_matrix;
  import e2r_pkg::*;

  localparam int LATENCY = 34;
  localparam int N_RAND  = 700;

  logic  clk = 0;
  logic  rst_n = 0;
  logic  in_valid = 0;
  logic  in_stall;
  in_t   in_data = '0;
  logic  out_valid;
  logic  out_stall = 0;
  out_t  out_data;
  int    fail_count;
  int    pending;
  bit    sink_busy = 1;
  int    sink_cycle = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  euler_to_rotation_matrix dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

  e2r_checker chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data), .fail_count(fail_count), .pending(pending)
  );

  // Pick a random angle: mostly in range, sometimes any 16-bit value
  function automatic field_t rand_angle();
    if ($urandom_range(0, 9) == 0) return field_t'($urandom());
    return field_t'($signed($urandom_range(0, 51472)) - 25736);
  endfunction

  // Offer one beat at the falling edge and hold it until accepted;
  // drop valid only for idle cycles so back-to-back beats need no gap
  task automatic send_beat(input in_t a, input bit calm);
    if (!calm) begin
      while ($urandom_range(0, 99) < 28) begin
        in_valid <= 0;
        @(negedge clk);
      end
    end
    in_valid <= 1;
    in_data  <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Sink: random stalls, one long hold-off early on, a calm stretch later
  always @(negedge clk) begin
    if (rst_n) sink_cycle <= sink_cycle + 1;
    if (sink_cycle < 40) begin
      out_stall <= 0;
    end else if (sink_cycle < 140) begin
      // hold off long enough for the pipe to fill and stall the input
      out_stall <= 1;
    end else if (sink_cycle >= 600 && sink_cycle < 900) begin
      out_stall <= 0;
    end else begin
      out_stall <= sink_busy && ($urandom_range(0, 99) < 28);
    end
  end

  initial begin
    field_t corner [8];
    in_t    a;
    corner = '{16'sd0, 16'sd25736, -16'sd25736, 16'sd12868, -16'sd12868,
               16'sd32767, -16'sd32768, 16'sd1};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    // directed: each corner on every axis, plus out-of-range clamping
    for (int i = 0; i < 8; i++) begin
      a = '{corner[i], corner[(i + 3) % 8], corner[(i + 5) % 8]};
      send_beat(a, 1);
      a = '{corner[i], corner[i], corner[i]};
      send_beat(a, 1);
    end
    for (int i = 0; i < N_RAND; i++) begin
      a = '{rand_angle(), rand_angle(), rand_angle()};
      // calm stretch for the sender in the middle of the run
      send_beat(a, i >= 300 && i < 400);
      if (i == 500) begin
        // drain: pause until every expected matrix has come back
        in_valid <= 0;
        while (pending != 0) @(negedge clk);
      end
    end
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("euler_to_rotation_matrix verification clean");
    end else begin
      $display("euler_to_rotation_matrix verification failed");
    end
    $finish;
  end

  initial begin
    #500000;
    $display("euler_to_rotation_matrix verification failed");
    $finish;
  end
endmodule

[filelist.f]
src/e2r_pkg.sv
src/e2r_cordic_cell.sv
src/euler_to_rotation_matrix.sv
sim/e2r_checker.sv
sim/tb_euler_to_rotation_matrix.sv
